>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants of the stable priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [55:0]        name_hi;
    logic [63:0]        name_lo;
    logic signed [7:0]  prio;
  } entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } cell_ctl_t;

  typedef struct packed {
    status_t           status;
    logic [63:0]       name_lo;
    logic [55:0]       name_hi;
    logic signed [7:0] prio;
    logic [4:0]        count;
  } result_t;

endpackage

>>> rtl/spq_if.sv
// ---------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for queue commands and results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spq_in_if;
  logic              valid;
  logic              ready;
  spq_pkg::cmd_t     cmd;
  logic [63:0]       name_lo;
  logic [55:0]       name_hi;
  logic signed [7:0] priority_req;

  modport source (output valid, cmd, name_lo, name_hi, priority_req, input ready);
  modport sink   (input valid, cmd, name_lo, name_hi, priority_req, output ready);
endinterface

interface spq_out_if;
  logic              valid;
  logic              ready;
  spq_pkg::status_t  status;
  logic [63:0]       out_name_lo;
  logic [55:0]       out_name_hi;
  logic signed [7:0] out_priority;
  logic [4:0]        entry_count;

  modport source (output valid, status, out_name_lo, out_name_hi, out_priority,
                  entry_count, input ready);
  modport sink   (input valid, status, out_name_lo, out_name_hi, out_priority,
                  entry_count, output ready);
endinterface

>>> rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One queue slot: compares against the new entry and shifts with neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               left_ga,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               ga,
  output spq_pkg::entry_t    entry_q
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // held entry stays ahead of the new one (lower or equal priority)
  assign ga = occ && ($signed(entry_r.prio) <= $signed(ctl.ent.prio));

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (!ga) begin
        entry_nxt = left_ga ? ctl.ent : left_entry;
      end
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

>>> rtl/stable_priority_queue.sv
// ---------------------------------------------------------------------------
// stable_priority_queue
// Sorted-insert priority queue built as a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Takes one command beat per clock unless the output stalls and returns one
// result beat per command from an output register in the next cycle; a new
// command is taken while the previous result is taken. Every cell compares
// its entry with the incoming one and moves in the same edge, so an insert
// or a remove costs the same at any fill level. Lower priority values leave
// first, equal priorities in arrival order. No clearing pass after reset.
`timescale 1ns / 1ps

module stable_priority_queue (
  input  logic            clk,
  input  logic            rst_n,
  spq_in_if.sink          in_ch,
  spq_out_if.source       out_ch
);

  localparam int D = spq_pkg::QUEUE_DEPTH;
  localparam int W = spq_pkg::CNT_W;

  logic [W-1:0]        count_r, count_nxt;
  logic                out_valid_r;
  spq_pkg::result_t    res_r, res_nxt;
  spq_pkg::cell_ctl_t  ctl;
  spq_pkg::entry_t     cell_q [D];
  spq_pkg::entry_t     new_ent, head, zero_ent;
  logic [D-1:0]        ga;
  logic                accept, full, empty, do_ins, do_rem;
  logic [31:0]         cnt32;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == W'(D));
  assign empty       = (count_r == '0);
  assign do_ins      = accept && (in_ch.cmd == spq_pkg::CMD_INSERT) && !full;
  assign do_rem      = accept && (in_ch.cmd == spq_pkg::CMD_REMOVE) && !empty;

  assign zero_ent = '0;
  assign new_ent  = '{name_hi: in_ch.name_hi, name_lo: in_ch.name_lo,
                      prio: in_ch.priority_req};
  assign head     = cell_q[0];
  assign ctl      = '{ins: do_ins, rem: do_rem, ent: new_ent};

  for (genvar i = 0; i < D; i++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;
    logic            left_g;
    logic            occ;

    assign occ = (W'(i) < count_r);
    if (i == 0) begin : g_first
      assign left_e = zero_ent;
      assign left_g = 1'b1;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_g = ga[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right_e = zero_ent;
    end else begin : g_body
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .left_ga    (left_g),
      .left_entry (left_e),
      .right_entry(right_e),
      .ga         (ga[i]),
      .entry_q    (cell_q[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - W'(1);
    end
  end

  assign cnt32 = 32'(count_nxt);

  always_comb begin
    res_nxt        = '0;
    res_nxt.count  = cnt32[4:0];
    res_nxt.status = spq_pkg::ST_OK;
    case (in_ch.cmd)
      spq_pkg::CMD_INSERT: begin
        if (full) begin
          res_nxt.status = spq_pkg::ST_FULL;
          res_nxt.name_lo = head.name_lo;
          res_nxt.name_hi = head.name_hi;
          res_nxt.prio    = head.prio;
        end else if (empty || ($signed(new_ent.prio) < $signed(head.prio))) begin
          res_nxt.name_lo = new_ent.name_lo;
          res_nxt.name_hi = new_ent.name_hi;
          res_nxt.prio    = new_ent.prio;
        end else begin
          res_nxt.name_lo = head.name_lo;
          res_nxt.name_hi = head.name_hi;
          res_nxt.prio    = head.prio;
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (empty) begin
          res_nxt.status = spq_pkg::ST_EMPTY;
        end else begin
          res_nxt.name_lo = head.name_lo;
          res_nxt.name_hi = head.name_hi;
          res_nxt.prio    = head.prio;
        end
      end
      default: begin
        res_nxt.status = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.out_name_lo  = res_r.name_lo;
  assign out_ch.out_name_hi  = res_r.name_hi;
  assign out_ch.out_priority = res_r.prio;
  assign out_ch.entry_count  = res_r.count;

endmodule

>>> rtl/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker
// Port-level checks on the queue results, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input spq_pkg::status_t  status,
  input logic signed [7:0] out_priority,
  input logic [4:0]        entry_count
);

  logic out_beat;
  logic in_beat;

  assign out_beat = out_valid && out_ready;
  assign in_beat  = in_valid && in_ready;

  `SPQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(entry_count))
  `SPQ_ASSERT_SAME(a_full_cnt, clk, rst_n, out_beat && status == spq_pkg::ST_FULL, entry_count == 5'(spq_pkg::QUEUE_DEPTH))
  `SPQ_ASSERT_SAME(a_empty, clk, rst_n, out_beat && status == spq_pkg::ST_EMPTY, entry_count == 5'd0 && out_priority == 8'sd0)
  `SPQ_ASSERT_NEXT(a_result, clk, rst_n, in_beat, out_valid)

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .out_priority(out_ch.out_priority),
  .entry_count (out_ch.entry_count)
);
